FILE: hdl/nsb_pkg.sv
`timescale 1ns / 1ps

package nsb_pkg;

  // Widths fixed by the stream and register formats
  localparam int BYTE_W       = 8;
  localparam int LEN_W        = 6;
  localparam int WORD_W       = 64;
  localparam int NUM_WORDS    = 4;
  localparam int NEEDLE_BITS  = WORD_W * NUM_WORDS;
  localparam int BYTES_MAX    = NEEDLE_BITS / BYTE_W;
  localparam int CFG_INDEX_W  = 3;
  localparam int VERDICT_W    = 2;
  localparam int M_TDATA_W    = 8;

  // Defaults for the top-level parameters
  localparam int MAX_NEEDLE_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_LENGTH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_WORD_0 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_WORD_3 = 3'd4;

  // Verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_CLEAN     = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_FOUND     = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_TOO_SMALL = 2'd2;

  // One classified byte, handed from the front to the back
  typedef struct packed {
    logic hit;        // window equals needle after this byte
    logic too_short;  // fewer bytes than needle seen so far
    logic last;       // final byte of the file
  } class_t;

endpackage

FILE: hdl/nsb_front.sv
`timescale 1ns / 1ps

module nsb_front #(
  parameter int MAX_NEEDLE = nsb_pkg::MAX_NEEDLE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // config write
  input  logic                                cfg_valid,
  input  logic [nsb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [nsb_pkg::WORD_W-1:0]          cfg_data,
  // byte in
  input  logic                                take,
  input  logic [nsb_pkg::BYTE_W-1:0]          text_byte,
  input  logic                                final_byte,
  output nsb_pkg::class_t                     cls
);

  localparam int SEEN_W = $clog2(MAX_NEEDLE + 1);
  localparam logic [nsb_pkg::LEN_W-1:0] MAX_LEN = nsb_pkg::LEN_W'(MAX_NEEDLE);

  // Raw registers
  logic [nsb_pkg::LEN_W-1:0]        needle_length;
  logic [nsb_pkg::LEN_W-1:0]        needle_length_next;
  logic [nsb_pkg::NEEDLE_BITS-1:0]  needle_flat;
  logic [nsb_pkg::NEEDLE_BITS-1:0]  needle_flat_next;

  // Needle pre-aligned to window lanes: lane i holds needle byte len-1-i
  logic [nsb_pkg::LEN_W-1:0]  eff_len;
  logic [nsb_pkg::LEN_W-1:0]  eff_len_next;
  logic [nsb_pkg::BYTE_W-1:0] aligned      [MAX_NEEDLE];
  logic [nsb_pkg::BYTE_W-1:0] aligned_next [MAX_NEEDLE];
  logic [MAX_NEEDLE-1:0]      lane_mask;
  logic [MAX_NEEDLE-1:0]      lane_mask_next;

  logic [nsb_pkg::BYTE_W-1:0] window     [MAX_NEEDLE];
  logic [nsb_pkg::BYTE_W-1:0] window_new [MAX_NEEDLE];
  logic [SEEN_W-1:0]          seen;
  logic [SEEN_W-1:0]          seen_new;
  logic [MAX_NEEDLE-1:0]      lane_ok;
  logic                       long_enough;

  // Config decode and lane alignment
  always_comb begin
    logic [nsb_pkg::LEN_W-1:0] k;
    needle_length_next = needle_length;
    needle_flat_next   = needle_flat;
    if (cfg_valid) begin
      if (cfg_index == nsb_pkg::REG_NEEDLE_LENGTH) begin
        needle_length_next = cfg_data[nsb_pkg::LEN_W-1:0];
      end else if (cfg_index >= nsb_pkg::REG_NEEDLE_WORD_0 &&
                   cfg_index <= nsb_pkg::REG_NEEDLE_WORD_3) begin
        needle_flat_next[(cfg_index - nsb_pkg::REG_NEEDLE_WORD_0) * nsb_pkg::WORD_W
                         +: nsb_pkg::WORD_W] = cfg_data;
      end
    end
    eff_len_next = (needle_length_next > MAX_LEN) ? MAX_LEN : needle_length_next;
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      k = eff_len_next - nsb_pkg::LEN_W'(i) - nsb_pkg::LEN_W'(1);
      lane_mask_next[i] = (nsb_pkg::LEN_W'(i) < eff_len_next);
      aligned_next[i]   = lane_mask_next[i] ?
                          needle_flat_next[k[4:0] * nsb_pkg::BYTE_W +: nsb_pkg::BYTE_W] :
                          '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_length <= nsb_pkg::LEN_W'(1);
      needle_flat   <= '0;
      eff_len       <= nsb_pkg::LEN_W'(1);
      lane_mask     <= MAX_NEEDLE'(1);
      for (int i = 0; i < MAX_NEEDLE; i++) begin
        aligned[i] <= '0;
      end
    end else if (cfg_valid) begin
      needle_length <= needle_length_next;
      needle_flat   <= needle_flat_next;
      eff_len       <= eff_len_next;
      lane_mask     <= lane_mask_next;
      aligned       <= aligned_next;
    end
  end

  // Window shift and parallel compare
  always_comb begin
    window_new[0] = text_byte;
    for (int i = 1; i < MAX_NEEDLE; i++) begin
      window_new[i] = window[i-1];
    end
    seen_new = (seen == SEEN_W'(MAX_NEEDLE)) ? seen : seen + SEEN_W'(1);
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      lane_ok[i] = !lane_mask[i] || (window_new[i] == aligned[i]);
    end
    long_enough   = (nsb_pkg::LEN_W'(seen_new) >= eff_len);
    cls.hit       = (&lane_ok) && long_enough;
    cls.too_short = !long_enough;
    cls.last      = final_byte;
  end

  // window entries past the byte count never decide a hit: no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      window <= window_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (take) begin
      seen <= final_byte ? '0 : seen_new;
    end
  end

endmodule

FILE: hdl/nsb_queue.sv
`timescale 1ns / 1ps

module nsb_queue #(
  parameter int DEPTH = nsb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  nsb_pkg::class_t push_data,
  output logic            full,
  input  logic            pop,
  output nsb_pkg::class_t pop_data,
  output logic            not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  nsb_pkg::class_t   slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      // push and pop together leave the count as it is
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: hdl/nsb_back.sv
`timescale 1ns / 1ps

module nsb_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  nsb_pkg::class_t                  q_data,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [nsb_pkg::VERDICT_W-1:0]    verdict
);

  logic found;
  logic found_next;
  logic slot_free;

  // a final byte needs the output slot; other bytes drain freely
  assign slot_free  = !out_valid || out_ready;
  assign q_pop      = q_valid && (!q_data.last || slot_free);
  assign found_next = found || q_data.hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a new verdict replaces the one taken in the same cycle
      if (q_pop && q_data.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        found <= q_data.last ? 1'b0 : found_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.last) begin
      priority if (q_data.too_short) begin
        verdict <= nsb_pkg::VERDICT_TOO_SMALL;
      end else if (found_next) begin
        verdict <= nsb_pkg::VERDICT_FOUND;
      end else begin
        verdict <= nsb_pkg::VERDICT_CLEAN;
      end
    end
  end

endmodule

FILE: hdl/byte_stream_needle_search.sv
`timescale 1ns / 1ps

// Needle search over a byte stream. Send the bytes of one file on the s_ side,
// with s_tlast on the final byte; one verdict comes back on the m_ side for
// every file: clean, found, or too small when the file is shorter than the
// needle. The needle (1 to MAX_NEEDLE bytes, length 0 matches every file,
// longer lengths clip to MAX_NEEDLE) is set through the config port and may
// be changed only while no file is in flight. Throughput is one byte per
// clock: the front keeps a shift window of the newest bytes and compares all
// lanes against a lane-aligned copy of the needle in the cycle a byte is
// accepted. Each classified byte then passes through a small queue
// (QUEUE_DEPTH entries) to the back, which folds the hits into a found flag
// and loads the verdict into the output register. With the output free, the
// final byte's class is written into the queue, then popped into the verdict
// register, which raises m_tvalid; s_tready drops only when the queue is full,
// i.e. when the verdict output has been held off.
module byte_stream_needle_search #(
  parameter int MAX_NEEDLE  = nsb_pkg::MAX_NEEDLE_DEF,   // 1..32
  parameter int QUEUE_DEPTH = nsb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // byte stream in
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [nsb_pkg::BYTE_W-1:0]        s_tdata,   // [7:0] text_byte
  input  logic                              s_tlast,   // final_byte
  // verdict out
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [nsb_pkg::M_TDATA_W-1:0]     m_tdata,   // [1:0] verdict, rest zero
  // config write: 0 needle_length, 1..4 needle_word_0..3
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nsb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [nsb_pkg::WORD_W-1:0]        cfg_data
);

  nsb_pkg::class_t                  cls;
  nsb_pkg::class_t                  q_data;
  logic                             take;
  logic                             q_full;
  logic                             q_valid;
  logic                             q_pop;
  logic [nsb_pkg::VERDICT_W-1:0]    verdict;

  // config writes are always taken
  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign take      = s_tvalid && s_tready;
  assign m_tdata   = {{(nsb_pkg::M_TDATA_W - nsb_pkg::VERDICT_W){1'b0}}, verdict};

  // front: window, compare, classify
  nsb_front #(
    .MAX_NEEDLE (MAX_NEEDLE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .take       (take),
    .text_byte  (s_tdata),
    .final_byte (s_tlast),
    .cls        (cls)
  );

  // decouples classification from verdict delivery
  nsb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (cls),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_valid)
  );

  // back: found flag and verdict register
  nsb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .verdict   (verdict)
  );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int BYTE_W = nsb_pkg::BYTE_W;
  localparam int WORD_W = nsb_pkg::WORD_W;
  localparam int NUM_WORDS = nsb_pkg::NUM_WORDS;
  localparam int NEEDLE_BITS = nsb_pkg::NEEDLE_BITS;
  localparam int CFG_INDEX_W = nsb_pkg::CFG_INDEX_W;
  localparam int VERDICT_W = nsb_pkg::VERDICT_W;
  localparam int M_TDATA_W = nsb_pkg::M_TDATA_W;

  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_LENGTH = nsb_pkg::REG_NEEDLE_LENGTH;
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_WORD_0 = nsb_pkg::REG_NEEDLE_WORD_0;
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_WORD_3 = nsb_pkg::REG_NEEDLE_WORD_3;

  localparam logic [VERDICT_W-1:0] VERDICT_CLEAN     = nsb_pkg::VERDICT_CLEAN;
  localparam logic [VERDICT_W-1:0] VERDICT_FOUND     = nsb_pkg::VERDICT_FOUND;
  localparam logic [VERDICT_W-1:0] VERDICT_TOO_SMALL = nsb_pkg::VERDICT_TOO_SMALL;

  localparam int WIN_BYTES = nsb_pkg::MAX_NEEDLE_DEF;
  localparam int REPORT_MAX = 10;
  localparam int PHASE_BYTES = 190;

  // Register indexes past the last needle word: writes there must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = REG_NEEDLE_WORD_3 + 1'b1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LAST = '1;

  // Idle profiles: none, sender gaps, receiver stalls, light on both sides
  localparam int SEND_IDLE[4] = '{0, 48, 0, 7};
  localparam int RECV_STALL[4] = '{0, 0, 48, 7};

  typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] idx;
    logic [WORD_W-1:0]      data;
    logic [BYTE_W-1:0]      text;
    logic                   last;
    bit                     pinned;    // verdict typed into the row
    logic [VERDICT_W-1:0]   verdict;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [BYTE_W-1:0]      s_tdata = '0;   // [7:0] text_byte
  logic                   s_tlast = 1'b0; // final_byte
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;        // [1:0] verdict, rest zero
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]      cfg_data = '0;

  // Typed verdict riding along with a directed final byte
  logic                 pin_valid = 1'b0;
  logic [VERDICT_W-1:0] pin_verdict = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Search state mirrored from the block
  logic [5:0]           needle_len_reg = 6'd1;
  logic [NEEDLE_BITS-1:0] needle_bits = '0;
  logic [BYTE_W-1:0]    win [WIN_BYTES];
  int                   seen = 0;
  bit                   found = 1'b0;

  logic [VERDICT_W-1:0] expected_verdicts[$];
  int mismatches = 0;
  int bytes_accepted = 0;
  int n_found = 0, n_clean = 0, n_short = 0, n_settings = 0;

  byte_stream_needle_search i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // Shift one byte into the window and return the verdict the file would get
  // if this byte were its last. Clears the file state on a final byte.
  function automatic logic [VERDICT_W-1:0] search_step(input logic [BYTE_W-1:0] b,
                                                       input logic last);
    int act;
    bit hit;
    logic [VERDICT_W-1:0] v;
    act = (needle_len_reg > WIN_BYTES) ? WIN_BYTES : int'(needle_len_reg);
    for (int i = WIN_BYTES - 1; i > 0; i--) win[i] = win[i-1];
    win[0] = b;
    if (seen < WIN_BYTES) seen++;
    // newest byte lines up with the last needle byte; length zero always hits
    hit = (seen >= act);
    for (int i = 0; i < act; i++)
      if (win[i] != needle_bits[(act-1-i)*8 +: 8]) hit = 1'b0;
    if (hit) found = 1'b1;
    // too short wins over a hit
    if (seen < act) v = VERDICT_TOO_SMALL;
    else v = found ? VERDICT_FOUND : VERDICT_CLEAN;
    if (last) begin
      foreach (win[i]) win[i] = '0;
      seen = 0;
      found = 1'b0;
    end
    return v;
  endfunction

  function automatic dir_row_t mk_row(row_kind_t kind, logic [CFG_INDEX_W-1:0] idx,
                                      logic [WORD_W-1:0] data, logic [BYTE_W-1:0] text,
                                      logic last, bit pinned, logic [VERDICT_W-1:0] v);
    dir_row_t r;
    r.kind = kind;
    r.idx = idx;
    r.data = data;
    r.text = text;
    r.last = last;
    r.pinned = pinned;
    r.verdict = v;
    return r;
  endfunction

  // Receiver side: random stalls per the current idle profile
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watch all three channels at the edge, keep the mirror in step, check verdicts
  always @(posedge clk) begin : watch
    logic [VERDICT_W-1:0] v;
    logic [M_TDATA_W-1:0] want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: verdict request with nothing pending: m_tdata=%0h", $realtime,
                     m_tdata);
        end else begin
          want = {{(M_TDATA_W-VERDICT_W){1'b0}}, expected_verdicts.pop_front()};
          if (m_tdata !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("%0t: verdict mismatch: expected %0h, got %0h", $realtime, want,
                       m_tdata);
          end
          case (want[VERDICT_W-1:0])
            VERDICT_FOUND:     n_found++;
            VERDICT_TOO_SMALL: n_short++;
            default:           n_clean++;
          endcase
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_NEEDLE_LENGTH)
          needle_len_reg = cfg_data[5:0];
        else if (cfg_index >= REG_NEEDLE_WORD_0 && cfg_index <= REG_NEEDLE_WORD_3)
          needle_bits[(cfg_index - REG_NEEDLE_WORD_0)*WORD_W +: WORD_W] = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        bytes_accepted++;
        v = search_step(s_tdata, s_tlast);
        if (s_tlast) expected_verdicts.push_back(pin_valid ? pin_verdict : v);
      end
    end
  end

  // Drop valid, let every pending verdict come back, then let the pipe settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write of a batch
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // One byte request, with optional random gap in front of it
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last, input bit pinned,
                           input logic [VERDICT_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    pin_valid <= pinned;
    pin_verdict <= v;
    do @(posedge clk); while (!s_tready);
  endtask

  initial begin : stimulus
    dir_row_t rows[$];
    bit in_cfg;
    logic [5:0] plan_len;
    logic [NEEDLE_BITS-1:0] plan_bits;
    logic [WORD_W-1:0] word;
    logic [BYTE_W-1:0] fbytes [80];
    int act, flen, pos, phase_items;
    bit noisy;

    foreach (win[i]) win[i] = '0;
    in_cfg = 1'b0;
    plan_bits = '0;

    // Reset state: one-byte needle of 0x00
    rows.push_back(mk_row(ROW_BYTE, '0, '0, 8'h00, 1'b1, 1'b1, VERDICT_FOUND));
    rows.push_back(mk_row(ROW_BYTE, '0, '0, 8'hFF, 1'b1, 1'b1, VERDICT_CLEAN));
    // Length zero (upper data bits ignored): every file matches
    rows.push_back(mk_row(ROW_WRITE, REG_NEEDLE_LENGTH, 64'hFFFF_FFFF_FFFF_FFC0, '0, 1'b0,
                          1'b0, VERDICT_CLEAN));
    rows.push_back(mk_row(ROW_BYTE, '0, '0, 8'h5A, 1'b1, 1'b1, VERDICT_FOUND));
    // Length 63 clips to 32, needle all ones: a 3-byte file is too small
    rows.push_back(mk_row(ROW_WRITE, REG_NEEDLE_LENGTH, 64'h3F, '0, 1'b0, 1'b0,
                          VERDICT_CLEAN));
    for (int w = 0; w < NUM_WORDS; w++)
      rows.push_back(mk_row(ROW_WRITE, CFG_INDEX_W'(REG_NEEDLE_WORD_0 + w), '1, '0, 1'b0,
                            1'b0, VERDICT_CLEAN));
    rows.push_back(mk_row(ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, VERDICT_CLEAN));
    rows.push_back(mk_row(ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, VERDICT_CLEAN));
    rows.push_back(mk_row(ROW_BYTE, '0, '0, 8'hFF, 1'b1, 1'b1, VERDICT_TOO_SMALL));
    // Needle 01 80 FF, then writes to spare indexes that must change nothing
    rows.push_back(mk_row(ROW_WRITE, REG_NEEDLE_LENGTH, 64'h3, '0, 1'b0, 1'b0,
                          VERDICT_CLEAN));
    rows.push_back(mk_row(ROW_WRITE, REG_NEEDLE_WORD_0, 64'h0000_0000_00FF_8001, '0, 1'b0,
                          1'b0, VERDICT_CLEAN));
    rows.push_back(mk_row(ROW_WRITE, REG_SPARE_FIRST, '1, '0, 1'b0, 1'b0, VERDICT_CLEAN));
    rows.push_back(mk_row(ROW_WRITE, REG_SPARE_LAST, '1, '0, 1'b0, 1'b0, VERDICT_CLEAN));
    // exact match, final byte completes it
    rows.push_back(mk_row(ROW_BYTE, '0, '0, 8'h01, 1'b0, 1'b0, VERDICT_CLEAN));
    rows.push_back(mk_row(ROW_BYTE, '0, '0, 8'h80, 1'b0, 1'b0, VERDICT_CLEAN));
    rows.push_back(mk_row(ROW_BYTE, '0, '0, 8'hFF, 1'b1, 1'b1, VERDICT_FOUND));
    // prefix only, file shorter than needle
    rows.push_back(mk_row(ROW_BYTE, '0, '0, 8'h01, 1'b0, 1'b0, VERDICT_CLEAN));
    rows.push_back(mk_row(ROW_BYTE, '0, '0, 8'h80, 1'b1, 1'b1, VERDICT_TOO_SMALL));
    // one bit off in the middle byte
    rows.push_back(mk_row(ROW_BYTE, '0, '0, 8'h01, 1'b0, 1'b0, VERDICT_CLEAN));
    rows.push_back(mk_row(ROW_BYTE, '0, '0, 8'h81, 1'b0, 1'b0, VERDICT_CLEAN));
    rows.push_back(mk_row(ROW_BYTE, '0, '0, 8'hFF, 1'b1, 1'b1, VERDICT_CLEAN));
    // match followed by more bytes: flag must stick
    rows.push_back(mk_row(ROW_BYTE, '0, '0, 8'h01, 1'b0, 1'b0, VERDICT_CLEAN));
    rows.push_back(mk_row(ROW_BYTE, '0, '0, 8'h80, 1'b0, 1'b0, VERDICT_CLEAN));
    rows.push_back(mk_row(ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, VERDICT_CLEAN));
    rows.push_back(mk_row(ROW_BYTE, '0, '0, 8'h00, 1'b1, 1'b1, VERDICT_FOUND));
    // near miss then a match at the tail
    rows.push_back(mk_row(ROW_BYTE, '0, '0, 8'h01, 1'b0, 1'b0, VERDICT_CLEAN));
    rows.push_back(mk_row(ROW_BYTE, '0, '0, 8'h80, 1'b0, 1'b0, VERDICT_CLEAN));
    rows.push_back(mk_row(ROW_BYTE, '0, '0, 8'hFE, 1'b0, 1'b0, VERDICT_CLEAN));
    rows.push_back(mk_row(ROW_BYTE, '0, '0, 8'h01, 1'b0, 1'b0, VERDICT_CLEAN));
    rows.push_back(mk_row(ROW_BYTE, '0, '0, 8'h80, 1'b0, 1'b0, VERDICT_CLEAN));
    rows.push_back(mk_row(ROW_BYTE, '0, '0, 8'hFF, 1'b1, 1'b1, VERDICT_FOUND));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[r]) begin
      if (rows[r].kind == ROW_WRITE) begin
        if (!in_cfg) begin
          wait_drained();
          in_cfg = 1'b1;
          n_settings++;
        end
        write_reg(rows[r].idx, rows[r].data);
      end else begin
        if (in_cfg) begin
          cfg_valid <= 1'b0;
          in_cfg = 1'b0;
        end
        push_byte(rows[r].text, rows[r].last, rows[r].pinned, rows[r].verdict);
      end
    end

    // Random phases: one needle setting and one idle profile each
    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      case (ph)
        0: plan_len = 6'd1;
        1: plan_len = 6'd32;
        2: plan_len = 6'd0;
        3: plan_len = 6'd4;
        4: plan_len = 6'd63;
        6: plan_len = 6'd2;
        default: plan_len = 6'($urandom_range(1, WIN_BYTES));
      endcase
      word = {$urandom, $urandom};
      word[5:0] = plan_len;
      write_reg(REG_NEEDLE_LENGTH, word);
      for (int w = 0; w < NUM_WORDS; w++) begin
        if (ph % 4 == 0 || $urandom_range(1)) begin
          case ($urandom_range(2))
            0: word = {$urandom, $urandom};
            1: for (int j = 0; j < 8; j++) word[j*8 +: 8] = $urandom_range(1) ? 8'hA5 : 8'h5A;
            default: word = $urandom_range(1) ? '0 : '1;
          endcase
          plan_bits[w*WORD_W +: WORD_W] = word;
          write_reg(CFG_INDEX_W'(REG_NEEDLE_WORD_0 + w), word);
        end
      end
      write_reg(CFG_INDEX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                {$urandom, $urandom});
      cfg_valid <= 1'b0;
      n_settings++;
      send_idle_pct = SEND_IDLE[ph % 4];
      recv_stall_pct = RECV_STALL[ph % 4];

      act = (plan_len > WIN_BYTES) ? WIN_BYTES : int'(plan_len);
      phase_items = 0;
      while (phase_items < PHASE_BYTES) begin
        // mostly files around the needle length, some up to twice that
        flen = ($urandom_range(4) == 0) ? $urandom_range(1, 2*act + 10)
                                        : $urandom_range(1, act + 6);
        noisy = $urandom_range(1);
        for (int i = 0; i < flen; i++)
          fbytes[i] = (noisy || act == 0) ? 8'($urandom)
                                          : plan_bits[$urandom_range(act-1)*8 +: 8];
        // plant the needle in about half the files, sometimes with one bit broken
        if (act > 0 && flen >= act && $urandom_range(1)) begin
          pos = $urandom_range(flen - act);
          for (int i = 0; i < act; i++) fbytes[pos+i] = plan_bits[i*8 +: 8];
          if ($urandom_range(3) == 0)
            fbytes[pos + $urandom_range(act-1)] ^= 8'(1 << $urandom_range(7));
        end
        for (int i = 0; i < flen; i++)
          push_byte(fbytes[i], i == flen - 1, 1'b0, VERDICT_CLEAN);
        phase_items += flen;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("Scanned %0d bytes under %0d needle settings, idle and stall profiles mixed.",
             bytes_accepted, n_settings);
    $display("Verdicts checked: %0d found, %0d clean, %0d too small; %0d mismatches.",
             n_found, n_clean, n_short, mismatches);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/nsb_pkg.sv
hdl/nsb_front.sv
hdl/nsb_queue.sv
hdl/nsb_back.sv
hdl/byte_stream_needle_search.sv
verif/tb_top.sv
